/* hw/rtl/mxt_pkg.sv */
// ----------------------------------------------------------------------------
// mxt_pkg
// Shared constants and types for the maximum XOR pair trie block.
// ----------------------------------------------------------------------------
package mxt_pkg;

  localparam int WIDTH      = 32;
  localparam int MAX_ITEMS  = 1024;
  localparam int POOL_NODES = MAX_ITEMS * WIDTH + 1;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int LVL_W      = (WIDTH > 1) ? $clog2(WIDTH) : 1;
  localparam int COUNT_W    = 11;
  localparam int LINK_W     = 2 * NODE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUERY,
    ST_UPDATE,
    ST_INSERT,
    ST_FINISH
  } state_t;

endpackage

/* hw/rtl/max_xor_pair_trie.sv */
// ----------------------------------------------------------------------------
// max_xor_pair_trie
// Maximum XOR over a set of values, held in a binary trie in node memory.
// ----------------------------------------------------------------------------
//  channel | signals                                  | flow
//  --------+------------------------------------------+---------------------
//  in      | in_valid, in_stall, value, last          | one value per word
//  out     | out_valid, out_stall, max_xor,           | one word per set,
//          | item_count, overflow                     | after the last value
//
//  One trie level per cycle through the node memory read port. A value takes
//  accept, query walk, max update, insert walk and finish; the first value of
//  a set skips query and update, and a dropped value goes straight to finish.
//  Reset clears the root links and counters; other nodes read as empty while
//  fresh and are linked when used, so the node memory needs no clearing pass.
//  A finished result waits in the output register; only the next last value
//  waits on out_stall.
// ----------------------------------------------------------------------------
module max_xor_pair_trie
  import mxt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         value,
  input  logic                last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         max_xor,
  output logic [COUNT_W-1:0]  item_count,
  output logic                overflow
);

  state_t state, state_next;

  logic [LINK_W-1:0] links_mem [POOL_NODES];
  logic [LINK_W-1:0] rd_data;
  logic              rd_en;
  logic [NODE_W-1:0] rd_addr;
  logic              wr_en;
  logic [NODE_W-1:0] wr_addr;
  logic [LINK_W-1:0] wr_data;

  logic [NODE_W-1:0]  node, node_next;
  logic               fresh, fresh_next;
  logic [LVL_W-1:0]   level, level_next;
  logic [WIDTH-1:0]   partner, partner_next;
  logic [WIDTH-1:0]   value_r, value_next;
  logic               last_r, last_next;
  logic [NODE_W-1:0]  root [2];
  logic [NODE_W-1:0]  root_next [2];
  logic [NODE_W-1:0]  node_count, node_count_next;
  logic [WIDTH-1:0]   running_max, running_max_next;
  logic [COUNT_W-1:0] items_held, items_held_next;
  logic               overflow_seen, overflow_seen_next;
  logic               out_valid_next;
  logic [31:0]        max_xor_next;
  logic [COUNT_W-1:0] item_count_next;
  logic               overflow_next;

  logic [NODE_W-1:0] cur [2];
  logic              bit_b;
  logic              want;
  logic              want_hit;
  logic              taken;
  logic [NODE_W-1:0] q_next_node;
  logic              q_stop;
  logic [NODE_W-1:0] i_next_node;
  logic [NODE_W-1:0] new_node;
  logic              pool_full;
  logic              set_full;
  logic              out_free;
  logic [WIDTH-1:0]  cand;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign set_full = (items_held >= COUNT_W'(MAX_ITEMS));

  always_comb begin
    if (node == '0) begin
      cur[0] = root[0];
      cur[1] = root[1];
    end else if (fresh) begin
      cur[0] = '0;
      cur[1] = '0;
    end else begin
      cur[0] = rd_data[NODE_W-1:0];
      cur[1] = rd_data[LINK_W-1:NODE_W];
    end
  end

  assign bit_b       = value_r[level];
  assign want        = ~bit_b;
  assign want_hit    = (cur[want] != '0);
  assign taken       = want_hit ? want : bit_b;
  assign q_next_node = want_hit ? cur[want] : cur[bit_b];
  assign q_stop      = (q_next_node == '0) ||
                       ({1'b0, q_next_node} >= (NODE_W + 1)'(POOL_NODES)) ||
                       (level == '0);
  assign i_next_node = cur[bit_b];
  assign new_node    = node_count + NODE_W'(1);
  assign pool_full   = (({1'b0, node_count} + (NODE_W + 1)'(1)) >=
                        (NODE_W + 1)'(POOL_NODES));
  assign cand        = value_r ^ partner;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (set_full) begin
            state_next = ST_FINISH;
          end else if (items_held == '0) begin
            state_next = ST_INSERT;
          end else begin
            state_next = ST_QUERY;
          end
        end
      end
      ST_QUERY: begin
        if (q_stop) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_INSERT;
      end
      ST_INSERT: begin
        if ((i_next_node == '0 && pool_full) || level == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!last_r || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    node_next          = node;
    fresh_next         = fresh;
    level_next         = level;
    partner_next       = partner;
    value_next         = value_r;
    last_next          = last_r;
    root_next[0]       = root[0];
    root_next[1]       = root[1];
    node_count_next    = node_count;
    running_max_next   = running_max;
    items_held_next    = items_held;
    overflow_seen_next = overflow_seen;
    out_valid_next     = out_valid && out_stall;
    max_xor_next       = max_xor;
    item_count_next    = item_count;
    overflow_next      = overflow;
    rd_en              = 1'b0;
    rd_addr            = node;
    wr_en              = 1'b0;
    wr_addr            = node;
    wr_data            = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          value_next   = value[WIDTH-1:0];
          last_next    = last;
          node_next    = '0;
          fresh_next   = 1'b0;
          level_next   = LVL_W'(WIDTH - 1);
          partner_next = '0;
          if (set_full) begin
            overflow_seen_next = 1'b1;
          end else begin
            items_held_next = items_held + COUNT_W'(1);
          end
        end
      end
      ST_QUERY: begin
        partner_next = {partner[WIDTH-2:0], taken};
        if (q_stop) begin
          node_next  = '0;
          level_next = LVL_W'(WIDTH - 1);
        end else begin
          node_next  = q_next_node;
          level_next = level - LVL_W'(1);
          rd_en      = 1'b1;
          rd_addr    = q_next_node;
        end
      end
      ST_UPDATE: begin
        if (cand > running_max) begin
          running_max_next = cand;
        end
      end
      ST_INSERT: begin
        level_next = level - LVL_W'(1);
        if (i_next_node != '0) begin
          node_next  = i_next_node;
          fresh_next = 1'b0;
          rd_en      = 1'b1;
          rd_addr    = i_next_node;
        end else if (pool_full) begin
          if (fresh && node != '0) begin
            wr_en   = 1'b1;
            wr_addr = node;
            wr_data = '0;
          end
        end else begin
          if (node == '0) begin
            root_next[bit_b] = new_node;
          end else begin
            wr_en   = 1'b1;
            wr_addr = node;
            wr_data = bit_b ? {new_node, cur[0]} : {cur[1], new_node};
          end
          node_count_next = new_node;
          node_next       = new_node;
          fresh_next      = 1'b1;
        end
      end
      ST_FINISH: begin
        if (last_r && out_free) begin
          out_valid_next     = 1'b1;
          max_xor_next       = running_max;
          item_count_next    = items_held;
          overflow_next      = overflow_seen;
          root_next[0]       = '0;
          root_next[1]       = '0;
          node_count_next    = '0;
          running_max_next   = '0;
          items_held_next    = '0;
          overflow_seen_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      links_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= links_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      root[0]       <= '0;
      root[1]       <= '0;
      node_count    <= '0;
      running_max   <= '0;
      items_held    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      root[0]       <= root_next[0];
      root[1]       <= root_next[1];
      node_count    <= node_count_next;
      running_max   <= running_max_next;
      items_held    <= items_held_next;
      overflow_seen <= overflow_seen_next;
      out_valid     <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    node       <= node_next;
    fresh      <= fresh_next;
    level      <= level_next;
    partner    <= partner_next;
    value_r    <= value_next;
    last_r     <= last_next;
    max_xor    <= max_xor_next;
    item_count <= item_count_next;
    overflow   <= overflow_next;
  end

  a_items_bound: assert property (@(posedge clk) disable iff (rst)
    items_held <= COUNT_W'(MAX_ITEMS))
    else $error("items held beyond set capacity");

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, node_count} < (NODE_W + 1)'(POOL_NODES))
    else $error("node count beyond pool");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH && $past(last_r))
    else $error("result word without a last value");

  a_query_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == ST_QUERY |-> items_held > COUNT_W'(1))
    else $error("query on a trie with no earlier value");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the maximum XOR pair trie block.
// Sends sets of values, each closed by a last word, and predicts every
// set's largest pairwise XOR, accepted count and drop flag. Result words are
// checked in order. Covers directed corner sets, random sets and a long
// output hold-off.
// ----------------------------------------------------------------------------
module tb
  import mxt_pkg::*;
;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 4 * WIDTH + 16;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 600;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } value_word_t;

  typedef struct packed {
    logic [31:0]        max_xor;
    logic [COUNT_W-1:0] count;
    logic               dropped;
  } set_result_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [31:0]        value     = '0;
  logic               last      = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [31:0]        max_xor;
  logic [COUNT_W-1:0] item_count;
  logic               overflow;

  value_word_t      pending_words[$];
  set_result_t      expected_sets[$];
  logic [WIDTH-1:0] set_values[$];
  logic [WIDTH-1:0] set_best    = '0;
  logic             set_dropped = 1'b0;
  bit               calm        = 1'b0;
  bit               hold_done   = 1'b0;
  int               hold_left   = 0;
  int               results_seen = 0;
  int               mismatches  = 0;
  longint           cycles      = 0;

  max_xor_pair_trie u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .max_xor    (max_xor),
    .item_count (item_count),
    .overflow   (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void note_mismatch(string msg);
    if (mismatches < 10) $display("MISMATCH: %s", msg);
    mismatches++;
  endfunction

  // fold one accepted word into the running set
  function automatic void absorb_word(value_word_t w);
    logic [WIDTH-1:0] v;
    v = w.value[WIDTH-1:0];
    if (set_values.size() >= MAX_ITEMS) begin
      set_dropped = 1'b1;
    end else begin
      foreach (set_values[i]) begin
        if ((v ^ set_values[i]) > set_best) set_best = v ^ set_values[i];
      end
      set_values.push_back(v);
    end
    if (w.last) begin
      expected_sets.push_back('{max_xor: 32'(set_best),
                                count: COUNT_W'(set_values.size()),
                                dropped: set_dropped});
      set_values.delete();
      set_best    = '0;
      set_dropped = 1'b0;
    end
  endfunction

  function automatic logic [31:0] pick_value(logic [31:0] base);
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(15);
      2: return base ^ (32'h1 << $urandom_range(31));
      3: return base ^ ($urandom & ((32'h1 << $urandom_range(31)) - 32'h1));
      4: return base;
      default: return ~$urandom_range(15);
    endcase
  endfunction

  task automatic queue_set(input logic [31:0] vals[$]);
    foreach (vals[i]) pending_words.push_back('{value: vals[i], last: i == vals.size() - 1});
  endtask

  task automatic queue_random_set(input int size);
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < size; i++) begin
      pending_words.push_back('{value: pick_value(base), last: i == size - 1});
    end
  endtask

  // sample after the edge settles so a word just loaded is seen
  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_sets.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  // driver: hold a word until taken, then load the next one or idle
  always @(posedge clk) begin
    value_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_word('{value: value, last: last});
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          value    <= w.value;
          last     <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result word, drive output stall
  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_sets.size() == 0) begin
          note_mismatch($sformatf("unexpected result max_xor %h count %0d overflow %b",
                                  max_xor, item_count, overflow));
        end else begin
          want = expected_sets.pop_front();
          if (max_xor !== want.max_xor || item_count !== want.count ||
              overflow !== want.dropped) begin
            note_mismatch($sformatf(
              "set %0d: max_xor %h exp %h, count %0d exp %0d, overflow %b exp %b",
              results_seen, max_xor, want.max_xor, item_count, want.count,
              overflow, want.dropped));
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && $urandom_range(99) < 11;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int sent;
    int size;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    queue_set({32'h0000_0000});
    queue_set({32'h0000_0000, 32'hFFFF_FFFF});
    queue_set({32'h0000_0007, 32'h0000_0007, 32'h0000_0007});
    queue_set({32'h8000_0000, 32'h7FFF_FFFF});
    queue_set({32'd3, 32'd10, 32'd5, 32'd25, 32'd2, 32'd8});
    queue_set({32'h0000_0000, 32'h0000_0000});
    queue_set({32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001});
    queue_set({32'h1234_5678, 32'h1234_5679});
    wait_drained();

    // random sets; the middle stretch runs with no idling
    for (int phase = 0; phase < 3; phase++) begin
      calm = (phase == 1);
      sent = 0;
      while (sent < RANDOM_ITEMS / 3) begin
        case ($urandom_range(19))
          0, 1, 2: size = $urandom_range(40, 9);
          3:       size = $urandom_range(120, 41);
          default: size = $urandom_range(8, 1);
        endcase
        queue_random_set(size);
        sent += size;
      end
      wait_drained();
    end
    calm = 1'b0;

    queue_set({32'h0000_0001, 32'h0000_0002});
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_sets.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
